@@ design/pcd_pkg.sv @@
package pcd_pkg;

  localparam logic [31:0] IDLE_WORD   = 32'd2055848343;
  localparam int          MAX_RESULTS = 8;
  localparam int          CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_ADDR  = 2'd0,
    KIND_NUM   = 2'd1,
    KIND_ALPHA = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  char_code;
    logic        char_error;
    logic [20:0] pager_address;
    logic [1:0]  function_bits;
  } result_t;

  typedef logic [CNT_W-1:0] count_t;

  // numeric digit table, nibble as received
  function automatic logic [6:0] num_char(input logic [3:0] nib);
    logic [6:0] c;
    unique case (nib)
      4'd0:    c = 7'h30;
      4'd1:    c = 7'h38;
      4'd2:    c = 7'h34;
      4'd3:    c = 7'h20;
      4'd4:    c = 7'h32;
      4'd5:    c = 7'h2F;
      4'd6:    c = 7'h36;
      4'd7:    c = 7'h5D;
      4'd8:    c = 7'h31;
      4'd9:    c = 7'h39;
      4'd10:   c = 7'h35;
      4'd11:   c = 7'h2D;
      4'd12:   c = 7'h33;
      4'd13:   c = 7'h55;
      4'd14:   c = 7'h37;
      default: c = 7'h5B;
    endcase
    return c;
  endfunction

  // alpha characters arrive lsb first
  function automatic logic [6:0] rev7(input logic [6:0] v);
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6]};
  endfunction

endpackage

@@ design/pcd_in_if.sv @@
interface pcd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] codeword;
  logic [3:0]  slot;
  logic        has_error;

  modport source (output valid, output codeword, output slot, output has_error, input ready);
  modport sink   (input valid, input codeword, input slot, input has_error, output ready);
endinterface

@@ design/pcd_out_if.sv @@
interface pcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [6:0]  char_code;
  logic        char_error;
  logic [20:0] pager_address;
  logic [1:0]  function_bits;
  logic        last;

  modport source (output valid, output kind, output char_code, output char_error,
                  output pager_address, output function_bits, output last, input ready);
  modport sink   (input valid, input kind, input char_code, input char_error,
                  input pager_address, input function_bits, input last, output ready);
endinterface

@@ design/pcd_decode.sv @@
module pcd_decode (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   advance,
  input  logic [31:0]                            codeword,
  input  logic [3:0]                             slot,
  input  logic                                   has_error,
  output pcd_pkg::result_t [pcd_pkg::MAX_RESULTS-1:0] res,
  output pcd_pkg::count_t                        res_count
);
  import pcd_pkg::*;

  logic       msg_open, msg_open_next;
  logic [6:0] carry_bits, carry_bits_next;
  logic [2:0] carry_count, carry_count_next;
  logic       carry_error, carry_error_next;

  always_comb begin
    logic [19:0] data;
    logic [26:0] joined;
    logic [26:0] aligned;
    logic [2:0]  shamt;
    logic [2:0]  avail;
    logic [6:0]  keep_mask;
    result_t     r;

    data    = codeword[30:11];
    joined  = {carry_bits, data};
    shamt   = (carry_count == 3'd0) ? 3'd0 : 3'd7 - carry_count;
    aligned = joined << shamt;
    avail   = (carry_count == 3'd0) ? 3'd6 : carry_count - 3'd1;
    keep_mask = 7'((8'd1 << avail) - 8'd1);

    res              = '0;
    res_count        = '0;
    msg_open_next    = msg_open;
    carry_bits_next  = carry_bits;
    carry_count_next = carry_count;
    carry_error_next = carry_error;
    r                = '0;

    priority if (codeword == IDLE_WORD) begin
      if (msg_open) begin
        r.kind           = KIND_END;
        res[0]           = r;
        res_count        = count_t'(1);
        msg_open_next    = 1'b0;
        carry_bits_next  = '0;
        carry_count_next = '0;
        carry_error_next = 1'b0;
      end
    end else if (!codeword[31]) begin
      r.kind          = KIND_ADDR;
      r.pager_address = {codeword[30:13], slot[3:1]};
      r.function_bits = codeword[12:11];
      if (msg_open) begin
        res[0].kind = KIND_END;
        res[1]      = r;
        res_count   = count_t'(2);
      end else begin
        res[0]    = r;
        res_count = count_t'(1);
      end
      msg_open_next    = 1'b1;
      carry_bits_next  = '0;
      carry_count_next = '0;
      carry_error_next = 1'b0;
    end else if (msg_open) begin
      for (int i = 0; i < 5; i++) begin
        res[i].kind       = KIND_NUM;
        res[i].char_code  = num_char(data[19-4*i -: 4]);
        res[i].char_error = has_error;
      end
      res[5].kind  = KIND_ALPHA;
      res[6].kind  = KIND_ALPHA;
      if (carry_count == 3'd0) begin
        // no partial character held: two whole characters, six bits left
        res[5].char_code  = rev7(aligned[19:13]);
        res[5].char_error = has_error;
        res[6].char_code  = rev7(aligned[12:6]);
        res[6].char_error = has_error;
        res_count         = count_t'(7);
      end else begin
        res[7].kind       = KIND_ALPHA;
        res[5].char_code  = rev7(aligned[26:20]);
        res[5].char_error = has_error | carry_error;
        res[6].char_code  = rev7(aligned[19:13]);
        res[6].char_error = has_error;
        res[7].char_code  = rev7(aligned[12:6]);
        res[7].char_error = has_error;
        res_count         = count_t'(8);
      end
      carry_count_next = avail;
      carry_bits_next  = {1'b0, data[5:0]} & keep_mask;
      carry_error_next = (avail != 3'd0) & has_error;
    end else begin
      // message word with no message open: dropped, state kept
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_open    <= 1'b0;
      carry_bits  <= '0;
      carry_count <= '0;
      carry_error <= 1'b0;
    end else if (advance) begin
      msg_open    <= msg_open_next;
      carry_bits  <= carry_bits_next;
      carry_count <= carry_count_next;
      carry_error <= carry_error_next;
    end
  end

endmodule

@@ design/pcd_emit.sv @@
module pcd_emit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load_valid,
  output logic                                   load_ready,
  input  pcd_pkg::result_t [pcd_pkg::MAX_RESULTS-1:0] load_res,
  input  pcd_pkg::count_t                        load_count,
  pcd_out_if.source                              results
);
  import pcd_pkg::*;

  result_t [MAX_RESULTS-1:0] burst;
  count_t                    remaining;
  logic                      busy;
  logic                      take;
  logic                      is_last;

  assign busy       = (remaining != '0);
  assign is_last    = (remaining == count_t'(1));
  assign take       = busy && results.ready;
  assign load_ready = !busy || (take && is_last);

  assign results.valid         = busy;
  assign results.kind          = burst[0].kind;
  assign results.char_code     = burst[0].char_code;
  assign results.char_error    = burst[0].char_error;
  assign results.pager_address = burst[0].pager_address;
  assign results.function_bits = burst[0].function_bits;
  assign results.last          = is_last;

  // burst shifts towards entry zero as each request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load_valid && load_ready) begin
      remaining <= load_count;
    end else if (take) begin
      remaining <= remaining - count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      burst <= load_res;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        burst[i] <= burst[i+1];
      end
      burst[MAX_RESULTS-1] <= '0;
    end
  end

endmodule

@@ design/pocsag_codeword_decoder.sv @@
// flow: an accepted codeword is held in the input register, decoded combinationally, and
// loaded into the result register, which offers its first request; the load waits on the shifter
// throughput: one codeword per cycle while each yields at most one request and results are
// taken; else the shifter paces it, one request per ready cycle, up to eight per message word
// reset: synchronous, active high; clears message state, partial alpha carry and all valids
module pocsag_codeword_decoder (
  input  logic       clk,
  input  logic       rst,
  pcd_in_if.sink     codewords,
  pcd_out_if.source  results
);
  import pcd_pkg::*;

  // input register: one codeword held for decoding
  logic        s0_valid;
  logic [31:0] s0_codeword;
  logic [3:0]  s0_slot;
  logic        s0_has_error;

  // decoded burst of requests for the held codeword
  result_t [MAX_RESULTS-1:0] dec_res;
  count_t                    dec_count;

  logic load_ready;
  logic advance;
  logic accept;

  // the held codeword moves on whenever the shifter is free or draining its last request;
  // codewords that give no request (idle with no message, stray message words) leave
  // the message state as it is
  assign advance         = s0_valid && load_ready;
  assign codewords.ready = !s0_valid || advance;
  assign accept          = codewords.valid && codewords.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (accept) begin
      s0_valid <= 1'b1;
    end else if (advance) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_codeword  <= codewords.codeword;
      s0_slot      <= codewords.slot;
      s0_has_error <= codewords.has_error;
    end
  end

  // decode: idle, address or message word against the open message and alpha carry
  pcd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .codeword  (s0_codeword),
    .slot      (s0_slot),
    .has_error (s0_has_error),
    .res       (dec_res),
    .res_count (dec_count)
  );

  // result register: holds the burst and offers one request per cycle while the receiver is ready
  pcd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s0_valid),
    .load_ready (load_ready),
    .load_res   (dec_res),
    .load_count (dec_count),
    .results    (results)
  );

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import pcd_pkg::*;

  // one expected decode: the result fields plus the end-of-codeword mark
  typedef struct packed {
    result_t res;
    logic    last;
  } pager_event_t;

  // digit glyphs indexed by the nibble as it sits in the codeword
  localparam logic [15:0][6:0] DIGIT_GLYPHS = {
    7'h5B, 7'h37, 7'h55, 7'h33, 7'h2D, 7'h35, 7'h39, 7'h31,
    7'h5D, 7'h36, 7'h2F, 7'h32, 7'h20, 7'h34, 7'h38, 7'h30
  };

  // quiet cycles tolerated before the run is declared hung
  localparam int WATCHDOG_LIMIT = 300;
  // settle time after the last result: covers the decoder latency plus margin
  localparam int DRAIN_SETTLE   = 12;

  logic clk;
  logic rst;

  pcd_in_if  cw_if ();
  pcd_out_if res_if ();

  pocsag_codeword_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .codewords (cw_if),
    .results   (res_if)
  );

  // decoded events still owed by the block, oldest first
  pager_event_t pager_events[$];

  // mirror of the decoder state: open message and the partial alpha character
  logic       msg_in_progress = 1'b0;
  logic [6:0] part_bits       = '0;
  logic [2:0] part_count      = '0;
  logic       part_error      = 1'b0;

  // idling controls
  bit         sender_gaps_on     = 1'b1;
  bit         receiver_stalls_on = 1'b1;
  int         burst_left         = 0;
  logic [7:0] stall_pattern      = 8'h5B;
  logic [2:0] stall_pos          = '0;

  // bookkeeping
  int error_count    = 0;
  int codewords_sent = 0;
  int decoded_items  = 0;
  int quiet_cycles   = 0;
  int seen_addr      = 0;
  int seen_digit     = 0;
  int seen_alpha     = 0;
  int seen_end       = 0;

  // 8 time unit period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // reference decoding
  // ---------------------------------------------------------------------------

  function automatic logic [6:0] mirror7(input logic [6:0] v);
    logic [6:0] r;
    int i;
    for (i = 0; i < 7; i++)
      r[6 - i] = v[i];
    return r;
  endfunction

  function automatic pager_event_t make_event(input kind_t k, input logic [6:0] code,
                                              input logic err, input logic [20:0] addr,
                                              input logic [1:0] fn);
    pager_event_t ev;
    ev.res.kind          = k;
    ev.res.char_code     = code;
    ev.res.char_error    = err;
    ev.res.pager_address = addr;
    ev.res.function_bits = fn;
    ev.last              = 1'b0;
    return ev;
  endfunction

  function automatic void drop_partial();
    part_bits  = '0;
    part_count = '0;
    part_error = 1'b0;
  endfunction

  // works out what one accepted codeword should produce, queues it, returns the count
  function automatic int decode_codeword(input logic [31:0] cw, input logic [3:0] slot,
                                         input logic err);
    pager_event_t outs [8];
    pager_event_t ev;
    logic [19:0]  data;
    int n;
    int k;
    int avail;
    int need;
    n = 0;
    if (cw == IDLE_WORD) begin
      // idle only matters when it closes a message
      if (msg_in_progress) begin
        outs[n] = make_event(KIND_END, '0, 1'b0, '0, '0);
        n++;
        msg_in_progress = 1'b0;
        drop_partial();
      end
    end else if (!cw[31]) begin
      // a new address ends whatever message was running, partial character lost
      if (msg_in_progress) begin
        outs[n] = make_event(KIND_END, '0, 1'b0, '0, '0);
        n++;
      end
      outs[n] = make_event(KIND_ADDR, '0, 1'b0, {cw[30:13], slot[3:1]}, cw[12:11]);
      n++;
      msg_in_progress = 1'b1;
      drop_partial();
    end else if (msg_in_progress) begin
      data = cw[30:11];
      // five numeric digits, most significant nibble first
      for (k = 0; k < 5; k++) begin
        outs[n] = make_event(KIND_NUM, DIGIT_GLYPHS[data[19 - 4 * k -: 4]], err, '0, '0);
        n++;
      end
      avail = 20;
      // finish the character left over from the previous word
      if (part_count != 0) begin
        need = 7 - part_count;
        outs[n] = make_event(KIND_ALPHA,
                             mirror7(7'((int'(part_bits) << need) | (int'(data) >> (20 - need)))),
                             err | part_error, '0, '0);
        n++;
        avail -= need;
      end
      while (avail >= 7) begin
        outs[n] = make_event(KIND_ALPHA, mirror7(7'(int'(data) >> (avail - 7))), err, '0, '0);
        n++;
        avail -= 7;
      end
      // leftover low bits wait for the next word
      if (avail > 0) begin
        part_bits  = 7'(int'(data) & ((1 << avail) - 1));
        part_count = 3'(avail);
        part_error = err;
      end else begin
        drop_partial();
      end
    end
    for (k = 0; k < n; k++) begin
      ev      = outs[k];
      ev.last = (k == n - 1);
      pager_events.push_back(ev);
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // codeword builders
  // ---------------------------------------------------------------------------

  // parity bits are left random, the block only looks at them in the idle word match
  function automatic logic [31:0] address_word(input logic [17:0] addr, input logic [1:0] fn);
    return {1'b0, addr, fn, 11'($urandom)};
  endfunction

  function automatic logic [31:0] message_word(input logic [19:0] data);
    return {1'b1, data, 11'($urandom)};
  endfunction

  function automatic logic random_flag();
    return ($urandom_range(0, 5) == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // one codeword request; valid stays high afterwards until the next call or hold_sender
  task automatic send_codeword(input logic [31:0] cw, input logic [3:0] slot, input logic err);
    int gap;
    int produced;
    gap = 0;
    if (sender_gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      cw_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cw_if.valid     <= 1'b1;
    cw_if.codeword  <= cw;
    cw_if.slot      <= slot;
    cw_if.has_error <= err;
    do @(posedge clk); while (!cw_if.ready);
    produced = decode_codeword(cw, slot, err);
    codewords_sent++;
    if (produced > 0)
      decoded_items++;
  endtask

  task automatic hold_sender();
    @(negedge clk);
    cw_if.valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (pager_events.size() != 0)
      @(posedge clk);
  endtask

  // stray traffic: random words, idles and message words that may find no message open
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0:       send_codeword($urandom, 4'($urandom), 1'($urandom));
      1:       send_codeword(IDLE_WORD, 4'($urandom), 1'($urandom));
      default: send_codeword(message_word(20'($urandom)), 4'($urandom), 1'($urandom));
    endcase
  endtask

  // address, a run of message words, then mostly an idle to close it
  task automatic random_message_round(input int max_words);
    int words;
    int ending;
    int w;
    logic [3:0] slot;
    slot = 4'($urandom);
    if ($urandom_range(0, 4) == 0)
      send_noise();
    send_codeword(address_word(18'($urandom), 2'($urandom)), slot, random_flag());
    words = $urandom_range(0, max_words);
    for (w = 0; w < words; w++) begin
      slot = slot + 4'd1;
      send_codeword(message_word(20'($urandom)), slot, random_flag());
    end
    ending = $urandom_range(0, 9);
    if (ending < 6)
      send_codeword(IDLE_WORD, slot + 4'd1, random_flag());
    else if (ending == 9)
      send_noise();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every digit nibble, the full cycle of alpha carry lengths,
  // and the idle / address corner cases
  task automatic test_directed_cases();
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    // idle with nothing open gives nothing
    send_codeword(IDLE_WORD, 4'd0, 1'b0);
    // message word with nothing open is ignored
    send_codeword(message_word(20'hFFFFF), 4'd1, 1'b1);
    // error flag on an address changes nothing
    send_codeword(address_word(18'h00000, 2'd0), 4'd0, 1'b1);
    // seven words walk the carry through every length and back to empty
    send_codeword(message_word(20'h01234), 4'd1, 1'b0);
    send_codeword(message_word(20'h56789), 4'd2, 1'b1);
    send_codeword(message_word(20'hABCDE), 4'd3, 1'b0);
    send_codeword(message_word(20'hF0000), 4'd4, 1'b0);
    send_codeword(message_word(20'hFFFFF), 4'd5, 1'b1);
    send_codeword(message_word(20'h00000), 4'd6, 1'b0);
    send_codeword(message_word(20'($urandom)), 4'd7, 1'b1);
    // address while a message is open: end first, then the address
    send_codeword(address_word(18'h3FFFF, 2'd3), 4'd15, 1'b0);
    // idle closes a message that still holds a partial character
    send_codeword(message_word(20'h5A5A5), 4'd0, 1'b1);
    send_codeword(IDLE_WORD, 4'd1, 1'b1);
    send_codeword(IDLE_WORD, 4'd2, 1'b0);
    // new address drops a held partial character
    send_codeword(address_word(18'h2AAAA, 2'd1), 4'd7, 1'b0);
    send_codeword(message_word(20'h12345), 4'd8, 1'b0);
    send_codeword(address_word(18'h15555, 2'd2), 4'd8, 1'b0);
    // all-ones and all-zero words in both formats
    send_codeword(32'hFFFF_FFFF, 4'd9, 1'b1);
    send_codeword(32'h7FFF_FFFF, 4'd14, 1'b0);
    send_codeword(32'h0000_0000, 4'd1, 1'b0);
    send_codeword(32'h8000_0000, 4'd2, 1'b0);
    send_codeword(IDLE_WORD, 4'd3, 1'b0);
  endtask

  // no idling on either side
  task automatic test_back_to_back(input int target);
    int stop_at;
    stop_at            = decoded_items + target;
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    while (decoded_items < stop_at)
      random_message_round(7);
  endtask

  // bursty sender and stalling receiver, occasionally long messages
  task automatic test_random_traffic(input int target);
    int stop_at;
    stop_at        = decoded_items + target;
    sender_gaps_on = 1'b1;
    while (decoded_items < stop_at) begin
      receiver_stalls_on = ($urandom_range(0, 3) != 0);
      random_message_round(($urandom_range(0, 3) == 0) ? 12 : 5);
    end
  endtask

  // sender stops and lets every owed result drain before going on
  task automatic test_paused_sender(input int rounds);
    int r;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    for (r = 0; r < rounds; r++) begin
      random_message_round(7);
      hold_sender();
      wait_for_drain();
      repeat (4) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver ready follows a rotating pattern, reloaded each lap; bit 0 always set
  always @(negedge clk) begin
    if (rst || !receiver_stalls_on) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= stall_pattern[stall_pos];
      if (stall_pos == 3'd7)
        stall_pattern <= 8'($urandom) | 8'h01;
      stall_pos <= stall_pos + 3'd1;
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // every accepted result request is matched against the oldest owed event
  always @(posedge clk) begin : check_pager_events
    pager_event_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pager_events.size() == 0) begin
        $display("%0t: unexpected result, kind %0h address %0h char %0h", $time,
                 res_if.kind, res_if.pager_address, res_if.char_code);
        error_count++;
      end else begin
        want = pager_events.pop_front();
        check_field("kind", want.res.kind, res_if.kind);
        check_field("char_code", want.res.char_code, res_if.char_code);
        check_field("char_error", want.res.char_error, res_if.char_error);
        check_field("pager_address", want.res.pager_address, res_if.pager_address);
        check_field("function_bits", want.res.function_bits, res_if.function_bits);
        check_field("last", want.last, res_if.last);
        case (want.res.kind)
          KIND_ADDR:  seen_addr++;
          KIND_NUM:   seen_digit++;
          KIND_ALPHA: seen_alpha++;
          default:    seen_end++;
        endcase
      end
    end
  end

  // hang detection: any accepted request on either side resets the count
  always @(posedge clk) begin
    if (rst || (cw_if.valid && cw_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, nothing accepted for %0d cycles, %0d results owed",
               $time, quiet_cycles, pager_events.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst              = 1'b1;
    cw_if.valid      = 1'b0;
    cw_if.codeword   = '0;
    cw_if.slot       = '0;
    cw_if.has_error  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_back_to_back(30);
    test_random_traffic(80);
    test_paused_sender(6);

    // let everything owed come out, then watch a little longer for strays
    hold_sender();
    wait_for_drain();
    repeat (DRAIN_SETTLE) @(posedge clk);

    if (pager_events.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pager_events.size());
      error_count++;
    end
    $display("covered %0d codewords, %0d of them producing results", codewords_sent,
             decoded_items);
    $display("checked %0d addresses, %0d digits, %0d alpha characters, %0d message ends",
             seen_addr, seen_digit, seen_alpha, seen_end);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
design/pcd_pkg.sv
design/pcd_in_if.sv
design/pcd_out_if.sv
design/pcd_decode.sv
design/pcd_emit.sv
design/pocsag_codeword_decoder.sv
tb/sv/testbench.sv
